/* hw/rtl/refcounted_block_allocator_unit_macros.svh */
// Assertion macros for the block allocator.
// Included by files that carry concurrent checks; no dependencies.
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define RBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define RBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* hw/rtl/rba_pkg.sv */
// Shared types and codes for the block allocator.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package rba_pkg;

  localparam int BLK_W    = 16;
  localparam int CNT_W    = 32;
  localparam int VAL_W    = 16;
  localparam int END_W    = 17;
  localparam int FCNT_W   = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 32;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_GET   = 3'd1,
    OP_SET   = 3'd2,
    OP_ADD   = 3'd3,
    OP_PUT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADADDR = 2'd2,
    ST_DOUBLE  = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

  localparam logic [BLK_W-1:0] LIMIT_RST  = 16'hFFFF;
  localparam logic [CNT_W-1:0] THRESH_RST = 32'd32768;

endpackage

`default_nettype wire

/* hw/rtl/rba_in_if.sv */
// Request channel of the block allocator: op, block and value.
// Depends on rba_pkg for field widths.
`default_nettype none

interface rba_in_if import rba_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              op;
  logic [BLK_W-1:0]        block;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output op, output block, output value, input ready);
  modport sink   (input valid, input op, input block, input value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rba_out_if.sv */
// Result channel of the block allocator: status, block, count and freed flag.
// Depends on rba_pkg for field widths.
`default_nettype none

interface rba_out_if import rba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [BLK_W-1:0] alloc_block;
  logic [CNT_W-1:0] count;
  logic             freed;

  modport source (output valid, output status, output alloc_block, output count,
                  output freed, input ready);
  modport sink   (input valid, input status, input alloc_block, input count,
                  input freed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rba_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/refcounted_block_allocator_unit.sv */
// Top level of the reference-counted block allocator with threaded free list.
// Depends on rba_pkg, rba_in_if, rba_out_if, rba_ram and the macros header.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid/ready   | op, block, value
//   out_ch   | out | valid/ready   | status, alloc_block, count, freed
//   cfg_*    | in  | cfg_we only   | cfg_idx, cfg_data
//
// Each word reads the count memory when accepted; in S_EXEC its count is
// written back where the op changes it and the output register is loaded.
// After reset a clearing pass zeroes every word of the count memory,
// with in_ch.ready low; configuration writes are taken throughout.
// A full output register holds the word in the write-back cycle until taken.
`default_nettype none

module refcounted_block_allocator_unit
  import rba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 65536,
  parameter int GROUP_SIZE  = 1024,
  parameter int FIRST_BLOCK = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rba_in_if.sink                    in_ch,
  rba_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data
);

`include "refcounted_block_allocator_unit_macros.svh"

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int GW = $clog2(GROUP_SIZE);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [BLK_W-1:0]   limit_r;
  logic [CNT_W-1:0]   thresh_r;
  logic [BLK_W-1:0]   head_r, head_nxt;
  logic [FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [END_W-1:0]   end_r, end_nxt;
  logic [GW-1:0]      grp_r, grp_nxt;

  logic [2:0]         op_r;
  logic [BLK_W-1:0]   blk_r;
  logic [VAL_W-1:0]   val_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [BLK_W-1:0]   out_blk_r, out_blk_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic               out_freed_r, out_freed_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CNT_W-1:0]   ram_wdata, ram_rdata;

  logic               accept, go;
  logic               skip;
  logic [END_W-1:0]   cand, cand_next;
  logic [CNT_W-1:0]   val_ext, cnt_dec, cnt_add;

  function automatic logic blk_ok(input logic [CNT_W-1:0] b, input logic [BLK_W-1:0] lim);
    return (b != '0) && (b < CNT_W'(lim)) && (b < CNT_W'(NUM_BLOCKS));
  endfunction

  rba_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BLOCKS)) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign go                 = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.alloc_block = out_blk_r;
  assign out_ch.count       = out_cnt_r;
  assign out_ch.freed       = out_freed_r;

  assign ram_re    = accept;
  assign ram_raddr = (in_ch.op == OP_ALLOC) ? AW'(head_r) : AW'(in_ch.block);

  assign skip      = (grp_r == '0);
  assign cand      = skip ? end_r + END_W'(2) : end_r;
  assign cand_next = skip ? end_r + END_W'(3) : end_r + END_W'(1);
  assign val_ext   = {{(CNT_W-VAL_W){val_r[VAL_W-1]}}, val_r};
  assign cnt_dec   = ram_rdata - CNT_W'(1);
  assign cnt_add   = ram_rdata + val_ext;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    fcnt_nxt       = fcnt_r;
    end_nxt        = end_r;
    grp_nxt        = grp_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(blk_r);
    ram_wdata      = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_cnt_nxt    = out_cnt_r;
    out_freed_nxt  = out_freed_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_blk_nxt    = '0;
          out_cnt_nxt    = '0;
          out_freed_nxt  = 1'b0;
          if (op_r == OP_ALLOC) begin
            if (head_r != '0) begin
              if (!blk_ok(CNT_W'(head_r), limit_r) ||
                  (ram_rdata != '0 && !blk_ok(ram_rdata, limit_r))) begin
                out_status_nxt = ST_BADADDR;
              end else begin
                head_nxt    = ram_rdata[BLK_W-1:0];
                fcnt_nxt    = (fcnt_r != '0) ? fcnt_r - FCNT_W'(1) : fcnt_r;
                ram_we      = 1'b1;
                ram_waddr   = AW'(head_r);
                ram_wdata   = CNT_W'(1);
                out_blk_nxt = head_r;
                out_cnt_nxt = CNT_W'(1);
              end
            end else if (!blk_ok(CNT_W'(cand), limit_r)) begin
              out_status_nxt = ST_FULL;
            end else begin
              end_nxt     = cand_next;
              grp_nxt     = skip ? GW'(3) :
                            ((grp_r == GW'(GROUP_SIZE - 1)) ? '0 : grp_r + GW'(1));
              ram_we      = 1'b1;
              ram_waddr   = AW'(cand);
              ram_wdata   = CNT_W'(1);
              out_blk_nxt = cand[BLK_W-1:0];
              out_cnt_nxt = CNT_W'(1);
            end
          end else if (op_r <= OP_PUT && blk_r != '0) begin
            if (!blk_ok(CNT_W'(blk_r), limit_r)) begin
              out_status_nxt = ST_BADADDR;
            end else begin
              unique case (op_r)
                OP_GET: begin
                  out_cnt_nxt = ram_rdata;
                end
                OP_SET: begin
                  ram_we      = 1'b1;
                  ram_wdata   = val_ext;
                  out_cnt_nxt = val_ext;
                end
                OP_ADD: begin
                  ram_we      = 1'b1;
                  ram_wdata   = cnt_add;
                  out_cnt_nxt = cnt_add;
                end
                default: begin
                  if (ram_rdata == '0 || ram_rdata > thresh_r) begin
                    out_status_nxt = ST_DOUBLE;
                    out_cnt_nxt    = ram_rdata;
                  end else if (cnt_dec != '0) begin
                    ram_we      = 1'b1;
                    ram_wdata   = cnt_dec;
                    out_cnt_nxt = cnt_dec;
                  end else begin
                    ram_we        = 1'b1;
                    ram_wdata     = CNT_W'(head_r);
                    head_nxt      = blk_r;
                    fcnt_nxt      = (fcnt_r != '1) ? fcnt_r + FCNT_W'(1) : fcnt_r;
                    out_freed_nxt = 1'b1;
                  end
                end
              endcase
            end
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      limit_r     <= LIMIT_RST;
      thresh_r    <= THRESH_RST;
      head_r      <= '0;
      fcnt_r      <= '0;
      end_r       <= END_W'(FIRST_BLOCK);
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      fcnt_r      <= fcnt_nxt;
      end_r       <= end_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_LIMIT:  limit_r  <= cfg_data[BLK_W-1:0];
          CFG_THRESH: thresh_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.op;
      blk_r <= in_ch.block;
      val_r <= in_ch.value;
    end
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  `RBA_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == S_EXEC)
  `RBA_ASSERT_NOW(a_idle_no_write, clk, rst_n, state_r == S_IDLE, !ram_we)
  `RBA_ASSERT_NOW(a_clear_blocks_in, clk, rst_n, state_r == S_CLEAR, !in_ch.ready)
  `RBA_ASSERT_NOW(a_out_from_exec, clk, rst_n, $rose(out_valid_r), $past(state_r == S_EXEC))
  `RBA_ASSERT_NOW(a_end_floor, clk, rst_n, 1'b1, end_r >= END_W'(FIRST_BLOCK))

endmodule

`default_nettype wire
